### design/tpeu_pkg.sv
package tpeu_pkg;

  // Default width of the saturating data byte position
  localparam int unsigned POSITION_WIDTH = 32;

  // Header length in bytes and field byte offsets
  localparam logic [3:0] HDR_LEN       = 4'd12;
  localparam logic [3:0] HDR_NAME_OFS  = 4'd4;
  localparam logic [3:0] HDR_ROWS_OFS  = 4'd8;
  localparam logic [3:0] HDR_RSVD_OFS  = 4'd10;

  // Entry flag bits
  localparam int unsigned FLG_NOTE = 6;
  localparam int unsigned FLG_VOL  = 5;
  localparam int unsigned FLG_FX   = 4;

  // Stored effect types
  localparam logic [7:0] FXT_VSLIDE_UP = 8'h01;
  localparam logic [7:0] FXT_VSLIDE_DN = 8'h04;
  localparam logic [7:0] FXT_PORTA_UP  = 8'h0C;
  localparam logic [7:0] FXT_PORTA_DN  = 8'h0E;
  localparam logic [7:0] FXT_JUMP      = 8'h33;
  localparam logic [7:0] FXT_BREAK     = 8'h34;
  localparam logic [7:0] FXT_SPEED     = 8'h3D;
  localparam logic [7:0] FXT_TEMPO     = 8'h3E;

  // Dense effect codes
  localparam logic [2:0] FX_NONE   = 3'd0;
  localparam logic [2:0] FX_VSLIDE = 3'd1;
  localparam logic [2:0] FX_PUP    = 3'd2;
  localparam logic [2:0] FX_PDN    = 3'd3;
  localparam logic [2:0] FX_JMP    = 3'd4;
  localparam logic [2:0] FX_BRK    = 3'd5;
  localparam logic [2:0] FX_SPD    = 3'd6;
  localparam logic [2:0] FX_TMP    = 3'd7;

  // Result kinds
  localparam logic KIND_EVENT = 1'b0;
  localparam logic KIND_END   = 1'b1;

  // Output tdata width
  localparam int unsigned OUT_DATA_W = 96;

  typedef enum logic [9:0] {
    PH_IDLE   = 10'b00_0000_0001,
    PH_HEADER = 10'b00_0000_0010,
    PH_FLAGS  = 10'b00_0000_0100,
    PH_CHAN   = 10'b00_0000_1000,
    PH_PEEK   = 10'b00_0001_0000,
    PH_NOTE   = 10'b00_0010_0000,
    PH_INS    = 10'b00_0100_0000,
    PH_VOL    = 10'b00_1000_0000,
    PH_FXT    = 10'b01_0000_0000,
    PH_FXP    = 10'b10_0000_0000
  } phase_t;

  // Fields of the event being assembled
  typedef struct packed {
    logic       has_note;
    logic [7:0] note;
    logic [7:0] instrument;
    logic       has_volume;
    logic [6:0] volume;
    logic [2:0] effect_code;
    logic [7:0] effect_param;
    logic [7:0] raw;
  } part_t;

  // One result item
  typedef struct packed {
    logic        kind;
    logic [15:0] row;
    logic [7:0]  channel;
    logic        has_note;
    logic [7:0]  note;
    logic [7:0]  instrument;
    logic        has_volume;
    logic [6:0]  volume;
    logic [2:0]  effect_code;
    logic [7:0]  effect_param;
    logic [31:0] pattern_name;
    logic        last;
  } res_t;

  // What one accepted byte produces: an event, a pattern end, or both
  typedef struct packed {
    logic ev;
    logic fin;
    res_t ev_res;
    res_t fin_res;
  } step_t;

  // Next optional part of an entry, FLAGS when the entry is complete
  function automatic phase_t next_part(input logic [7:0] flags, input logic room0,
                                       input logic room1, input logic from_note,
                                       input logic from_vol);
    phase_t ph;
    if (from_note && flags[FLG_NOTE] && room1) begin
      ph = PH_NOTE;
    end else if (from_vol && flags[FLG_VOL] && room0) begin
      ph = PH_VOL;
    end else if (flags[FLG_FX] && room1) begin
      ph = PH_FXT;
    end else begin
      ph = PH_FLAGS;
    end
    return ph;
  endfunction

  // Octave/semitone to linear note; zero and values from 0x80 pass unchanged
  function automatic logic [7:0] conv_note(input logic [7:0] n);
    logic [7:0] oct12;
    oct12 = {3'b000, n[6:4], 2'b00} + {2'b00, n[6:4], 3'b000};
    if (n != 8'h00 && !n[7]) begin
      return oct12 + {4'h0, n[3:0]} + 8'd13;
    end
    return n;
  endfunction

endpackage

### design/tracker_pattern_event_unpacker_unit.sv
// Pattern chunk event unpacker. Takes one chunk byte per item and can accept a
// byte every cycle: each byte is decoded in a single pass against the parser
// state and its results (an event, a pattern end, or both) go into a
// three-entry result queue. Input is taken while the queue holds at most one
// result, so with the output side always ready the rate is one byte per cycle;
// a byte that yields two results holds off input until one has been popped.
// Results appear on the output in the cycle after their byte, at the earliest.
// A pattern end carries the header name and row count and is always last of
// its byte's results; bytes arriving outside a chunk are dropped.
module tracker_pattern_event_unpacker_unit #(
  parameter int unsigned POSITION_WIDTH = tpeu_pkg::POSITION_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] chunk_start
  input  logic        in_tlast,   // chunk_end
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] row, [23:16] channel, [24] has_note, [32:25] note,
  // [40:33] instrument, [41] has_volume, [48:42] volume, [51:49] effect_code,
  // [59:52] effect_param, [91:60] pattern_name, [95:92] zero
  output logic [tpeu_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic        out_tuser,  // [0] kind
  output logic        out_tlast   // last_of_run
);

  tpeu_pkg::step_t step;
  tpeu_pkg::res_t  slot_r [3];
  tpeu_pkg::res_t  slot_nxt [3];
  logic [1:0]      count_r, count_nxt;
  logic [1:0]      base;
  logic            accept, pop;

  assign in_tready = count_r <= 2'd1;
  assign accept    = in_tvalid && in_tready;
  assign pop       = out_tvalid && out_tready;

  tpeu_parser #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .data_byte   (in_tdata),
    .chunk_start (in_tuser),
    .chunk_end   (in_tlast),
    .step        (step)
  );

  // Result queue: head in slot 0, shift on pop, up to two writes per cycle
  always_comb begin
    slot_nxt[0] = pop ? slot_r[1] : slot_r[0];
    slot_nxt[1] = pop ? slot_r[2] : slot_r[1];
    slot_nxt[2] = slot_r[2];
    base        = count_r - {1'b0, pop};
    count_nxt   = base;
    if (accept) begin
      if (step.ev) slot_nxt[base] = step.ev_res;
      if (step.fin) slot_nxt[step.ev ? base + 2'd1 : base] = step.fin_res;
      count_nxt = base + {1'b0, step.ev} + {1'b0, step.fin};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  // Output packing
  assign out_tvalid = count_r != 2'd0;
  assign out_tuser  = slot_r[0].kind;
  assign out_tlast  = slot_r[0].last;
  assign out_tdata  = {4'h0, slot_r[0].pattern_name, slot_r[0].effect_param,
                       slot_r[0].effect_code, slot_r[0].volume, slot_r[0].has_volume,
                       slot_r[0].instrument, slot_r[0].note, slot_r[0].has_note,
                       slot_r[0].channel, slot_r[0].row};

  // Queue never holds more than three results
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3 || !accept)
    else $error("byte accepted with full result queue");

  // A pattern end is always the last result of its byte
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("pattern end not marked last");

  // Events carry no pattern name
  a_event_name: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[91:60] == 32'h0)
    else $error("event with nonzero pattern name");

endmodule

### design/tpeu_parser.sv
module tpeu_parser #(
  parameter int unsigned POSITION_WIDTH = tpeu_pkg::POSITION_WIDTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [7:0]      data_byte,
  input  logic            chunk_start,
  input  logic            chunk_end,
  output tpeu_pkg::step_t step
);

  localparam int unsigned CMP_W = 33;

  tpeu_pkg::phase_t      phase_r, phase_nxt;
  logic [3:0]            hdr_idx_r, hdr_idx_nxt;
  logic [31:0]           size_r, size_nxt;
  logic [31:0]           name_r, name_nxt;
  logic [15:0]           rows_r, rows_nxt;
  logic [POSITION_WIDTH-1:0] pos_r, pos_nxt;
  logic [15:0]           row_r, row_nxt;
  logic [7:0]            flags_r, flags_nxt;
  logic [7:0]            chan_r, chan_nxt;
  logic [7:0]            prev_r, prev_nxt;
  tpeu_pkg::part_t       part_r, part_nxt;

  logic                  ev, fin;
  logic                  room0, room1;
  logic [CMP_W-1:0]      pos_ext;
  logic [POSITION_WIDTH-1:0] pos_bump;
  logic [POSITION_WIDTH-1:0] pos_nxt_pre;
  logic [31:0]               size_pre;

  // Saturating position bump and room checks on the bumped value
  always_comb begin
    pos_bump = (pos_nxt_pre == '1) ? pos_nxt_pre : pos_nxt_pre + 1'b1;
    pos_ext  = {{(CMP_W-POSITION_WIDTH){1'b0}}, pos_bump};
    room0    = pos_ext < {1'b0, size_pre};
    room1    = (pos_ext + 1'b1) < {1'b0, size_pre};
  end

  // Position and size as seen after a possible chunk start
  assign pos_nxt_pre = chunk_start ? '0 : pos_r;
  assign size_pre    = chunk_start ? '0 : size_r;

  // Step logic: one byte per accepted item
  always_comb begin
    tpeu_pkg::phase_t ph;
    phase_nxt   = phase_r;
    hdr_idx_nxt = hdr_idx_r;
    size_nxt    = size_r;
    name_nxt    = name_r;
    rows_nxt    = rows_r;
    pos_nxt     = pos_r;
    row_nxt     = row_r;
    flags_nxt   = flags_r;
    chan_nxt    = chan_r;
    prev_nxt    = prev_r;
    part_nxt    = part_r;
    ev          = 1'b0;
    fin         = 1'b0;
    ph          = tpeu_pkg::PH_FLAGS;

    // A new chunk clears everything
    if (chunk_start) begin
      phase_nxt   = tpeu_pkg::PH_HEADER;
      hdr_idx_nxt = '0;
      size_nxt    = '0;
      name_nxt    = '0;
      rows_nxt    = '0;
      pos_nxt     = '0;
      row_nxt     = '0;
      flags_nxt   = '0;
      chan_nxt    = '0;
      prev_nxt    = '0;
      part_nxt    = '0;
    end

    case (phase_nxt)
      tpeu_pkg::PH_HEADER: begin
        if (hdr_idx_nxt < tpeu_pkg::HDR_NAME_OFS) begin
          case (hdr_idx_nxt[1:0])
            2'd0:    size_nxt[7:0]   = data_byte;
            2'd1:    size_nxt[15:8]  = data_byte;
            2'd2:    size_nxt[23:16] = data_byte;
            default: size_nxt[31:24] = data_byte;
          endcase
        end else if (hdr_idx_nxt < tpeu_pkg::HDR_ROWS_OFS) begin
          case (hdr_idx_nxt[1:0])
            2'd0:    name_nxt[7:0]   = data_byte;
            2'd1:    name_nxt[15:8]  = data_byte;
            2'd2:    name_nxt[23:16] = data_byte;
            default: name_nxt[31:24] = data_byte;
          endcase
        end else if (hdr_idx_nxt < tpeu_pkg::HDR_RSVD_OFS) begin
          if (hdr_idx_nxt[0]) rows_nxt[15:8] = data_byte;
          else                rows_nxt[7:0]  = data_byte;
        end
        hdr_idx_nxt = hdr_idx_nxt + 1'b1;
        if (hdr_idx_nxt >= tpeu_pkg::HDR_LEN) begin
          phase_nxt = tpeu_pkg::PH_FLAGS;
          if (rows_nxt == '0) fin = 1'b1;
        end
      end
      tpeu_pkg::PH_FLAGS: begin
        pos_nxt = pos_bump;
        if (data_byte == 8'h00) begin
          fin = 1'b1;
        end else begin
          flags_nxt = data_byte;
          phase_nxt = tpeu_pkg::PH_CHAN;
        end
      end
      tpeu_pkg::PH_CHAN: begin
        pos_nxt  = pos_bump;
        chan_nxt = data_byte;
        if (flags_nxt[7:4] == 4'h1 && data_byte <= prev_nxt && room1) begin
          phase_nxt = tpeu_pkg::PH_PEEK;
        end else if (!room0) begin
          fin = 1'b1;
        end else if (flags_nxt[7:4] == 4'h0) begin
          // Plain row advance
          row_nxt  = row_nxt + 1'b1;
          prev_nxt = data_byte;
          if (row_nxt >= rows_nxt) fin = 1'b1;
          else phase_nxt = tpeu_pkg::PH_FLAGS;
        end else begin
          part_nxt = '0;
          ph = tpeu_pkg::next_part(flags_nxt, room0, room1, 1'b1, 1'b1);
          phase_nxt = ph;
          if (ph == tpeu_pkg::PH_FLAGS) ev = 1'b1;
        end
      end
      tpeu_pkg::PH_PEEK: begin
        // Lookahead byte: low nibble zero means a row break and a new flags byte
        if (data_byte[3:0] == 4'h0) begin
          row_nxt  = row_nxt + 1'b1;
          prev_nxt = chan_nxt;
          if (row_nxt >= rows_nxt) begin
            fin = 1'b1;
          end else begin
            pos_nxt = pos_bump;
            if (data_byte == 8'h00) begin
              fin = 1'b1;
            end else begin
              flags_nxt = data_byte;
              phase_nxt = tpeu_pkg::PH_CHAN;
            end
          end
        end else begin
          part_nxt     = '0;
          pos_nxt      = pos_bump;
          part_nxt.raw = data_byte;
          phase_nxt    = tpeu_pkg::PH_FXP;
        end
      end
      tpeu_pkg::PH_NOTE: begin
        pos_nxt      = pos_bump;
        part_nxt.raw = data_byte;
        phase_nxt    = tpeu_pkg::PH_INS;
      end
      tpeu_pkg::PH_INS: begin
        pos_nxt             = pos_bump;
        part_nxt.note       = tpeu_pkg::conv_note(part_nxt.raw);
        part_nxt.instrument = data_byte;
        part_nxt.has_note   = 1'b1;
        ph = tpeu_pkg::next_part(flags_nxt, room0, room1, 1'b0, 1'b1);
        phase_nxt = ph;
        if (ph == tpeu_pkg::PH_FLAGS) ev = 1'b1;
      end
      tpeu_pkg::PH_VOL: begin
        pos_nxt             = pos_bump;
        part_nxt.volume     = data_byte[7:1];
        part_nxt.has_volume = 1'b1;
        ph = tpeu_pkg::next_part(flags_nxt, room0, room1, 1'b0, 1'b0);
        phase_nxt = ph;
        if (ph == tpeu_pkg::PH_FLAGS) ev = 1'b1;
      end
      tpeu_pkg::PH_FXT: begin
        pos_nxt      = pos_bump;
        part_nxt.raw = data_byte;
        phase_nxt    = tpeu_pkg::PH_FXP;
      end
      tpeu_pkg::PH_FXP: begin
        logic [8:0] half;
        half    = ({1'b0, data_byte} + 9'd1) >> 1;
        pos_nxt = pos_bump;
        case (part_nxt.raw)
          tpeu_pkg::FXT_VSLIDE_UP: begin
            part_nxt.effect_code  = tpeu_pkg::FX_VSLIDE;
            part_nxt.effect_param = data_byte | 8'h0F;
          end
          tpeu_pkg::FXT_VSLIDE_DN: begin
            part_nxt.effect_code  = tpeu_pkg::FX_VSLIDE;
            part_nxt.effect_param = {4'h0, data_byte[7:4]} | 8'hF0;
          end
          tpeu_pkg::FXT_PORTA_UP: begin
            part_nxt.effect_code  = tpeu_pkg::FX_PUP;
            part_nxt.effect_param = half[7:0];
          end
          tpeu_pkg::FXT_PORTA_DN: begin
            part_nxt.effect_code  = tpeu_pkg::FX_PDN;
            part_nxt.effect_param = half[7:0];
          end
          tpeu_pkg::FXT_JUMP: begin
            part_nxt.effect_code  = tpeu_pkg::FX_JMP;
            part_nxt.effect_param = data_byte;
          end
          tpeu_pkg::FXT_BREAK: begin
            part_nxt.effect_code  = tpeu_pkg::FX_BRK;
            part_nxt.effect_param = data_byte;
          end
          tpeu_pkg::FXT_SPEED: begin
            part_nxt.effect_code  = tpeu_pkg::FX_SPD;
            part_nxt.effect_param = data_byte;
          end
          tpeu_pkg::FXT_TEMPO: begin
            part_nxt.effect_code  = tpeu_pkg::FX_TMP;
            part_nxt.effect_param = data_byte;
          end
          default: begin
            part_nxt.effect_code  = tpeu_pkg::FX_NONE;
            part_nxt.effect_param = 8'h00;
          end
        endcase
        ev = 1'b1;
      end
      default: begin
      end
    endcase

    // Emitted event: previous channel follows, parser waits for flags
    if (ev) begin
      prev_nxt  = chan_nxt;
      phase_nxt = tpeu_pkg::PH_FLAGS;
    end
    if (fin) phase_nxt = tpeu_pkg::PH_IDLE;

    // Chunk end: flush an event in progress, then close the pattern
    if (chunk_end && phase_nxt != tpeu_pkg::PH_IDLE) begin
      if (phase_nxt == tpeu_pkg::PH_NOTE || phase_nxt == tpeu_pkg::PH_INS ||
          phase_nxt == tpeu_pkg::PH_VOL || phase_nxt == tpeu_pkg::PH_FXT ||
          phase_nxt == tpeu_pkg::PH_FXP) begin
        ev = 1'b1;
      end
      fin       = 1'b1;
      phase_nxt = tpeu_pkg::PH_IDLE;
    end
  end

  // Result items of this byte
  always_comb begin
    step.ev                      = ev;
    step.fin                     = fin;
    step.ev_res.kind             = tpeu_pkg::KIND_EVENT;
    step.ev_res.row              = row_nxt;
    step.ev_res.channel          = chan_nxt;
    step.ev_res.has_note         = part_nxt.has_note;
    step.ev_res.note             = part_nxt.has_note ? part_nxt.note : 8'h00;
    step.ev_res.instrument       = part_nxt.has_note ? part_nxt.instrument : 8'h00;
    step.ev_res.has_volume       = part_nxt.has_volume;
    step.ev_res.volume           = part_nxt.has_volume ? part_nxt.volume : 7'h00;
    step.ev_res.effect_code      = part_nxt.effect_code;
    step.ev_res.effect_param     = part_nxt.effect_param;
    step.ev_res.pattern_name     = '0;
    step.ev_res.last             = !fin;
    step.fin_res                 = '0;
    step.fin_res.kind            = tpeu_pkg::KIND_END;
    step.fin_res.row             = rows_nxt;
    step.fin_res.pattern_name    = name_nxt;
    step.fin_res.last            = 1'b1;
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= tpeu_pkg::PH_IDLE;
    end else if (accept) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hdr_idx_r <= hdr_idx_nxt;
      size_r    <= size_nxt;
      name_r    <= name_nxt;
      rows_r    <= rows_nxt;
      pos_r     <= pos_nxt;
      row_r     <= row_nxt;
      flags_r   <= flags_nxt;
      chan_r    <= chan_nxt;
      prev_r    <= prev_nxt;
      part_r    <= part_nxt;
    end
  end

endmodule

### tb/tb_tracker_pattern_event_unpacker_unit.sv
`timescale 1ns / 1ps

module tb_tracker_pattern_event_unpacker_unit;

  // One chunk byte as it travels on the input channel
  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
  } chunk_byte_t;

  // Event fields collected while an entry is decoded
  typedef struct packed {
    logic       has_note;
    logic [7:0] note;
    logic [7:0] instrument;
    logic       has_volume;
    logic [6:0] volume;
    logic [2:0] fx_code;
    logic [7:0] fx_param;
  } entry_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [tpeu_pkg::OUT_DATA_W-1:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  tracker_pattern_event_unpacker_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  chunk_byte_t    byte_q[$];
  chunk_byte_t    drv_item;
  tpeu_pkg::res_t decoded_q[$];
  logic [7:0]  body_q[$];
  int unsigned queued_cnt = 0;
  int unsigned taken_cnt = 0;
  int unsigned fail_cnt = 0;
  int unsigned send_gap_pct = 0;
  int unsigned recv_gap_pct = 0;

  // Parser mirror
  tpeu_pkg::phase_t ph = tpeu_pkg::PH_IDLE;
  logic [3:0]  hdr_idx = '0;
  logic [31:0] decl_size = '0;
  logic [31:0] name_w = '0;
  logic [15:0] row_lim = '0;
  logic [31:0] pos = '0;
  logic [15:0] row_cnt = '0;
  logic [7:0]  flags = '0;
  logic [7:0]  chan = '0;
  logic [7:0]  prev_chan = '0;
  logic [7:0]  raw_note = '0;
  logic [7:0]  raw_fxt = '0;
  entry_t      ev = '0;
  logic        done = 1'b1;
  tpeu_pkg::res_t step_res[2];
  int unsigned step_n;

  function automatic bit fits(int unsigned k);
    return ({1'b0, pos} + 33'(k)) < {1'b0, decl_size};
  endfunction

  // Saturating data byte position
  function automatic void bump_pos();
    if (pos != '1) pos++;
  endfunction

  function automatic void push_res(tpeu_pkg::res_t r);
    if (step_n < 2) begin
      step_res[step_n] = r;
      step_n++;
    end
  endfunction

  function automatic tpeu_pkg::res_t entry_result();
    tpeu_pkg::res_t r;
    r = '0;
    r.kind = tpeu_pkg::KIND_EVENT;
    r.row = row_cnt;
    r.channel = chan;
    r.has_note = ev.has_note;
    if (ev.has_note) begin
      r.note = ev.note;
      r.instrument = ev.instrument;
    end
    r.has_volume = ev.has_volume;
    if (ev.has_volume) r.volume = ev.volume;
    r.effect_code = ev.fx_code;
    r.effect_param = ev.fx_param;
    return r;
  endfunction

  function automatic void close_pattern();
    tpeu_pkg::res_t r;
    r = '0;
    r.kind = tpeu_pkg::KIND_END;
    r.row = row_lim;
    r.pattern_name = name_w;
    push_res(r);
    done = 1'b1;
    ph = tpeu_pkg::PH_IDLE;
  endfunction

  function automatic void emit_entry();
    push_res(entry_result());
    prev_chan = chan;
    ph = tpeu_pkg::PH_FLAGS;
  endfunction

  // stage: 0 from note, 1 from volume, 2 from effect
  function automatic void next_field(int unsigned stage);
    if (stage == 0 && flags[tpeu_pkg::FLG_NOTE] && fits(1)) ph = tpeu_pkg::PH_NOTE;
    else if (stage <= 1 && flags[tpeu_pkg::FLG_VOL] && fits(0)) ph = tpeu_pkg::PH_VOL;
    else if (flags[tpeu_pkg::FLG_FX] && fits(1)) ph = tpeu_pkg::PH_FXT;
    else emit_entry();
  endfunction

  function automatic void flags_byte(logic [7:0] b);
    bump_pos();
    if (b == 8'h00) begin
      close_pattern();
    end else begin
      flags = b;
      ph = tpeu_pkg::PH_CHAN;
    end
  endfunction

  // Decode one accepted item and queue the results it causes
  function automatic void decode_chunk_byte(logic [7:0] b, logic st, logic en);
    logic [7:0] n;
    step_n = 0;
    if (st) begin
      hdr_idx = '0;
      decl_size = '0;
      name_w = '0;
      row_lim = '0;
      pos = '0;
      row_cnt = '0;
      flags = '0;
      chan = '0;
      prev_chan = '0;
      ev = '0;
      done = 1'b0;
      ph = tpeu_pkg::PH_HEADER;
    end
    if (!done) begin
      case (ph)
        tpeu_pkg::PH_HEADER: begin
          case (hdr_idx[3:2])
            2'd0: decl_size[8*hdr_idx[1:0] +: 8] = b;
            2'd1: name_w[8*hdr_idx[1:0] +: 8] = b;
            default: if (!hdr_idx[1]) row_lim[8*hdr_idx[0] +: 8] = b;
          endcase
          hdr_idx++;
          if (hdr_idx >= tpeu_pkg::HDR_LEN) begin
            ph = tpeu_pkg::PH_FLAGS;
            if (row_lim == 16'd0) close_pattern();
          end
        end
        tpeu_pkg::PH_FLAGS: flags_byte(b);
        tpeu_pkg::PH_CHAN: begin
          bump_pos();
          chan = b;
          if (flags[7:4] == 4'h1 && b <= prev_chan && fits(1)) begin
            ph = tpeu_pkg::PH_PEEK;
          end else if (!fits(0)) begin
            close_pattern();
          end else if (flags[7:4] == 4'h0) begin
            row_cnt++;
            prev_chan = chan;
            if (row_cnt >= row_lim) close_pattern();
            else ph = tpeu_pkg::PH_FLAGS;
          end else begin
            ev = '0;
            next_field(0);
          end
        end
        tpeu_pkg::PH_PEEK: begin
          // low nibble zero: new row, byte is the next flags byte
          if (b[3:0] == 4'h0) begin
            row_cnt++;
            prev_chan = chan;
            if (row_cnt >= row_lim) close_pattern();
            else flags_byte(b);
          end else begin
            ev = '0;
            bump_pos();
            raw_fxt = b;
            ph = tpeu_pkg::PH_FXP;
          end
        end
        tpeu_pkg::PH_NOTE: begin
          bump_pos();
          raw_note = b;
          ph = tpeu_pkg::PH_INS;
        end
        tpeu_pkg::PH_INS: begin
          bump_pos();
          n = raw_note;
          if (n != 8'h00 && n < 8'h80) n = 8'(n[6:4]) * 8'd12 + 8'(n[3:0]) + 8'd13;
          ev.note = n;
          ev.instrument = b;
          ev.has_note = 1'b1;
          next_field(1);
        end
        tpeu_pkg::PH_VOL: begin
          bump_pos();
          ev.volume = b[7:1];
          ev.has_volume = 1'b1;
          next_field(2);
        end
        tpeu_pkg::PH_FXT: begin
          bump_pos();
          raw_fxt = b;
          ph = tpeu_pkg::PH_FXP;
        end
        tpeu_pkg::PH_FXP: begin
          bump_pos();
          ev.fx_param = b;
          case (raw_fxt)
            tpeu_pkg::FXT_VSLIDE_UP: begin
              ev.fx_code = tpeu_pkg::FX_VSLIDE;
              ev.fx_param = b | 8'h0F;
            end
            tpeu_pkg::FXT_VSLIDE_DN: begin
              ev.fx_code = tpeu_pkg::FX_VSLIDE;
              ev.fx_param = {4'hF, b[7:4]};
            end
            tpeu_pkg::FXT_PORTA_UP: begin
              ev.fx_code = tpeu_pkg::FX_PUP;
              ev.fx_param = 8'((9'(b) + 9'd1) >> 1);
            end
            tpeu_pkg::FXT_PORTA_DN: begin
              ev.fx_code = tpeu_pkg::FX_PDN;
              ev.fx_param = 8'((9'(b) + 9'd1) >> 1);
            end
            tpeu_pkg::FXT_JUMP:  ev.fx_code = tpeu_pkg::FX_JMP;
            tpeu_pkg::FXT_BREAK: ev.fx_code = tpeu_pkg::FX_BRK;
            tpeu_pkg::FXT_SPEED: ev.fx_code = tpeu_pkg::FX_SPD;
            tpeu_pkg::FXT_TEMPO: ev.fx_code = tpeu_pkg::FX_TMP;
            default: begin
              ev.fx_code = tpeu_pkg::FX_NONE;
              ev.fx_param = 8'h00;
            end
          endcase
          emit_entry();
        end
        default: ;
      endcase
    end
    // chunk end: flush a begun event, then close the pattern
    if (en && !done) begin
      if (ph inside {tpeu_pkg::PH_NOTE, tpeu_pkg::PH_INS, tpeu_pkg::PH_VOL,
                     tpeu_pkg::PH_FXT, tpeu_pkg::PH_FXP}) push_res(entry_result());
      close_pattern();
    end
    if (step_n > 0) step_res[step_n-1].last = 1'b1;
    for (int i = 0; i < step_n; i++) decoded_q.push_back(step_res[i]);
  endfunction

  // Driver: feeds queued items, random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        decode_chunk_byte(drv_item.data, drv_item.first, drv_item.last);
        taken_cnt++;
      end
      if (!in_tvalid || in_tready) begin
        if (byte_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          drv_item = byte_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= drv_item.data;
          in_tuser <= drv_item.first;
          in_tlast <= drv_item.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string nm, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", nm, want, got);
      fail_cnt++;
    end
  endfunction

  // Monitor: compares each result item with the oldest expectation
  always @(posedge clk) begin
    tpeu_pkg::res_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (decoded_q.size() == 0) begin
          $error("result item with none expected: tdata %0h", out_tdata);
          fail_cnt++;
        end else begin
          want = decoded_q.pop_front();
          check_field("kind", 32'(want.kind), 32'(out_tuser));
          check_field("row", 32'(want.row), 32'(out_tdata[15:0]));
          check_field("channel", 32'(want.channel), 32'(out_tdata[23:16]));
          check_field("has_note", 32'(want.has_note), 32'(out_tdata[24]));
          check_field("note", 32'(want.note), 32'(out_tdata[32:25]));
          check_field("instrument", 32'(want.instrument), 32'(out_tdata[40:33]));
          check_field("has_volume", 32'(want.has_volume), 32'(out_tdata[41]));
          check_field("volume", 32'(want.volume), 32'(out_tdata[48:42]));
          check_field("effect_code", 32'(want.effect_code), 32'(out_tdata[51:49]));
          check_field("effect_param", 32'(want.effect_param), 32'(out_tdata[59:52]));
          check_field("pattern_name", want.pattern_name, out_tdata[91:60]);
          check_field("pad", 32'd0, 32'(out_tdata[95:92]));
          check_field("last_of_run", 32'(want.last), 32'(out_tlast));
        end
      end
      out_tready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  task automatic queue_byte(input logic [7:0] d, input logic first, input logic last);
    byte_q.push_back('{d, first, last});
    queued_cnt++;
  endtask

  // Header then body_q; only the first n_send bytes go out
  task automatic send_chunk(input logic [31:0] size, input logic [31:0] name,
                            input logic [15:0] rows, input int unsigned n_send,
                            input bit mark_end);
    logic [7:0] hdr[12];
    logic [7:0] d;
    for (int i = 0; i < 4; i++) begin
      hdr[i] = size[8*i +: 8];
      hdr[4+i] = name[8*i +: 8];
    end
    hdr[8] = rows[7:0];
    hdr[9] = rows[15:8];
    hdr[10] = 8'($urandom);
    hdr[11] = 8'($urandom);
    for (int i = 0; i < n_send; i++) begin
      d = (i < 12) ? hdr[i] : body_q[i-12];
      queue_byte(d, i == 0, mark_end && i == n_send - 1);
    end
  endtask

  task automatic random_chunk();
    int unsigned r;
    int unsigned total;
    int unsigned n_send;
    logic [7:0]  fl;
    logic [7:0]  nt;
    logic [31:0] size;
    logic [15:0] rows;
    bit          row_break;
    bit          force_lo;
    body_q.delete();
    force_lo = 1'b0;
    repeat ($urandom_range(2, 10)) begin
      r = $urandom_range(99);
      row_break = 1'b0;
      if (r < 3) begin
        fl = 8'h00;
      end else if (r < 18) begin
        fl = {4'h0, 4'($urandom_range(1, 15))};
      end else if (r < 34) begin
        // lookahead candidate; half of them are a bare row break
        fl = {4'h1, 4'($urandom)};
        row_break = 1'($urandom_range(1));
      end else begin
        fl = 8'($urandom);
      end
      if (force_lo && fl[7:4] != 4'h0) fl[3:0] = 4'h0;
      force_lo = row_break;
      body_q.push_back(fl);
      body_q.push_back(($urandom_range(99) < 80) ? 8'($urandom_range(7)) : 8'($urandom));
      if (fl[tpeu_pkg::FLG_NOTE]) begin
        r = $urandom_range(99);
        if (r < 10) nt = 8'h00;
        else if (r < 20) nt = {1'b1, 7'($urandom)};
        else if (r < 80) nt = {1'b0, 3'($urandom), 4'($urandom_range(11))};
        else nt = 8'($urandom);
        body_q.push_back(nt);
        body_q.push_back(8'($urandom));
      end
      if (fl[tpeu_pkg::FLG_VOL]) body_q.push_back(8'($urandom));
      if (fl[tpeu_pkg::FLG_FX] && !row_break) begin
        case ($urandom_range(9))
          0: body_q.push_back(tpeu_pkg::FXT_VSLIDE_UP);
          1: body_q.push_back(tpeu_pkg::FXT_VSLIDE_DN);
          2: body_q.push_back(tpeu_pkg::FXT_PORTA_UP);
          3: body_q.push_back(tpeu_pkg::FXT_PORTA_DN);
          4: body_q.push_back(tpeu_pkg::FXT_JUMP);
          5: body_q.push_back(tpeu_pkg::FXT_BREAK);
          6: body_q.push_back(tpeu_pkg::FXT_SPEED);
          7: body_q.push_back(tpeu_pkg::FXT_TEMPO);
          default: body_q.push_back(8'($urandom));
        endcase
        body_q.push_back(8'($urandom));
      end
    end
    r = $urandom_range(99);
    if (r < 5) rows = 16'd0;
    else if (r < 8) rows = 16'hFFFF;
    else if (r < 10) rows = 16'($urandom);
    else rows = 16'($urandom_range(1, 8));
    r = $urandom_range(99);
    if (r < 60) size = body_q.size();
    else if (r < 75) size = (body_q.size() > 4) ? body_q.size() - $urandom_range(1, 4) : 0;
    else if (r < 90) size = body_q.size() + $urandom_range(1, 8);
    else size = $urandom;
    total = 12 + body_q.size();
    n_send = ($urandom_range(99) < 15) ? $urandom_range(1, total) : total;
    send_chunk(size, $urandom, rows, n_send, $urandom_range(99) < 85);
    // stray bytes between chunks
    if ($urandom_range(99) < 20) begin
      repeat ($urandom_range(1, 3)) queue_byte(8'($urandom), 1'b0, 1'($urandom));
    end
  endtask

  // Holds off until every queued item is taken and every result has come
  task automatic wait_idle();
    while (!(taken_cnt == queued_cnt && decoded_q.size() == 0)) @(posedge clk);
  endtask

  task automatic random_phase(input int unsigned n_items);
    int unsigned target;
    target = queued_cnt + n_items;
    while (queued_cnt < target) random_chunk();
    wait_idle();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    send_gap_pct = 19;
    recv_gap_pct = 70;

    // full entry with extremes, lookahead row break, volume+tempo, zero flags end
    body_q = '{8'h7F, 8'h05, 8'h7B, 8'hFF, 8'hFF, tpeu_pkg::FXT_PORTA_UP, 8'hFF,
               8'h1F, 8'h02, 8'h30, 8'h00, 8'h00, tpeu_pkg::FXT_TEMPO, 8'h00, 8'h00};
    send_chunk(32'd16, 32'hFFFF_FFFF, 16'hFFFF, 12 + body_q.size(), 1'b1);
    // one-byte chunk: start and end together
    body_q.delete();
    send_chunk(32'd0, 32'd0, 16'd0, 1, 1'b1);
    // ignored while no chunk is open
    queue_byte(8'hFF, 1'b0, 1'b0);
    wait_idle();

    random_phase(130);
    send_gap_pct = 70;
    recv_gap_pct = 19;
    random_phase(130);
    send_gap_pct = 0;
    recv_gap_pct = 0;
    random_phase(130);

    repeat (10) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
